[rtl/snfd_pkg.sv]
// Package for the sorted nearest/farthest distance block.
// Holds capacity and width constants, the input/output word types and the command type.
// No dependencies.
package snfd_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CoordBits = 32;

  typedef struct packed {
    logic signed [CoordBits-1:0] coordinate;
    logic                        last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_value;
    logic [CoordBits-1:0]        nearest_distance;
    logic [CoordBits-1:0]        farthest_distance;
    logic                        truncated;
    logic                        last_result;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // empty the chain
    logic insert;   // insert the input key into the chain
    logic shift;    // shift the chain down by one (emit step)
  } dp_cmd_t;

endpackage

[rtl/snfd_chain.sv]
// Sorted insertion chain and emit datapath.
// Depends on snfd_pkg. Keys are held in offset binary so unsigned order is signed order.
module snfd_chain #(
  parameter int unsigned MaxPoints = snfd_pkg::MaxPoints,
  parameter int unsigned CoordBits = snfd_pkg::CoordBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  snfd_pkg::dp_cmd_t       cmd_i,
  input  logic [CoordBits-1:0]    key_i,
  output logic                    full_o,
  output logic                    two_left_o,
  output logic                    one_left_o,
  output logic [CoordBits-1:0]    head_o,
  output logic [CoordBits-1:0]    near_o,
  output logic [CoordBits-1:0]    far_o
);

  logic [CoordBits-1:0] cell_q [MaxPoints];
  logic [CoordBits-1:0] cell_d [MaxPoints];
  logic [MaxPoints-1:0] vld_q, vld_d;
  logic [MaxPoints-1:0] gt;
  logic [CoordBits-1:0] lo_q, lo_d, hi_q, hi_d, prev_q, prev_d;
  logic                 first_q, first_d;

  // Compare the key against every cell: a valid cell larger than the key moves down.
  always_comb begin
    for (int i = 0; i < MaxPoints; i++) begin
      gt[i] = vld_q[i] && (cell_q[i] > key_i);
    end
  end

  // Clear, insert into or shift the chain.
  always_comb begin
    vld_d   = vld_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    prev_d  = prev_q;
    first_d = first_q;
    for (int i = 0; i < MaxPoints; i++) cell_d[i] = cell_q[i];
    if (cmd_i.clear) begin
      vld_d   = '0;
      first_d = 1'b1;
    end else if (cmd_i.insert) begin
      for (int i = 0; i < MaxPoints; i++) begin
        if (i == 0) begin
          if (gt[0] || !vld_q[0]) cell_d[0] = key_i;
        end else if (gt[i]) begin
          cell_d[i] = gt[i-1] ? cell_q[i-1] : key_i;
        end else if (vld_q[i-1] && !vld_q[i]) begin
          cell_d[i] = gt[i-1] ? cell_q[i-1] : key_i;
        end
      end
      vld_d = {vld_q[MaxPoints-2:0], 1'b1};
    end else if (cmd_i.shift) begin
      if (first_q) begin
        lo_d = cell_q[0];
        for (int i = 0; i < MaxPoints; i++) begin
          if (vld_q[i]) hi_d = cell_q[i];
        end
      end
      first_d = 1'b0;
      prev_d  = cell_q[0];
      for (int i = 0; i < MaxPoints - 1; i++) cell_d[i] = cell_q[i+1];
      vld_d = {1'b0, vld_q[MaxPoints-1:1]};
    end
  end

  // Distances for the head cell.
  logic [CoordBits-1:0] lo_v, hi_v, da, db, dl, dh;
  logic                 has_prev, has_next;
  always_comb begin
    lo_v = lo_q;
    hi_v = hi_q;
    if (first_q) begin
      lo_v = cell_q[0];
      for (int i = 0; i < MaxPoints; i++) begin
        if (vld_q[i]) hi_v = cell_q[i];
      end
    end
    has_prev = !first_q;
    has_next = vld_q[1];
    da = cell_q[0] - prev_q;
    db = cell_q[1] - cell_q[0];
    dl = cell_q[0] - lo_v;
    dh = hi_v - cell_q[0];
    far_o = (dl > dh) ? dl : dh;
    if (has_prev && has_next) near_o = (da < db) ? da : db;
    else if (has_prev)        near_o = da;
    else if (has_next)        near_o = db;
    else                      near_o = '0;
    if (!has_prev && !has_next) far_o = '0;
  end

  assign head_o     = cell_q[0];
  assign full_o     = vld_q[MaxPoints-1];
  assign one_left_o = vld_q[0] && !vld_q[1];
  assign two_left_o = vld_q[1];

  // Hold chain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      first_q <= 1'b1;
    end else begin
      vld_q   <= vld_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxPoints; i++) cell_q[i] <= cell_d[i];
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    prev_q <= prev_d;
  end

endmodule

[rtl/snfd_ctrl.sv]
// Controller: load phase, then emit phase into the top level's registered output word, then a clear state.
// Depends on snfd_pkg.
module snfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              last_i,
  input  logic              out_busy_i,
  input  logic              full_i,
  input  logic              one_left_i,
  output snfd_pkg::dp_cmd_t cmd_o,
  output logic              emit_o,
  output logic              trunc_o
);

  typedef enum logic [1:0] {ST_LOAD, ST_EMIT, ST_CLEAR} state_e;
  state_e state_q;
  logic   ovf_q;

  assign in_ready_o = (state_q == ST_LOAD);
  assign emit_o     = (state_q == ST_EMIT) && !out_busy_i;
  assign trunc_o    = ovf_q;

  // Decode commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_LOAD:  cmd_o.insert = in_valid_i && !full_i;
      ST_EMIT:  cmd_o.shift  = emit_o;
      ST_CLEAR: cmd_o.clear  = 1'b1;
      default:  cmd_o        = '0;
    endcase
  end

  // Advance state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            if (full_i) ovf_q <= 1'b1;
            if (last_i) state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_o && one_left_i) state_q <= ST_CLEAR;
        end
        ST_CLEAR: begin
          ovf_q   <= 1'b0;
          state_q <= ST_LOAD;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

endmodule

[rtl/sorted_nearest_farthest_distance.sv]
// Top level of the sorted nearest/farthest distance block.
// Depends on snfd_pkg, snfd_chain and snfd_ctrl.
//
//   port group | dir | word type
//   in_*       | in  | snfd_pkg::in_word_t
//   out_*      | out | snfd_pkg::out_word_t
//
// While loading, the insertion chain sorts each accepted point in place.
// After the last point, one result per cycle leaves the output register while the
// output is not stalled, then the clear state empties the chain.
// Reset empties the chain. A stalled output holds its word and the chain.
module sorted_nearest_farthest_distance #(
  parameter int unsigned MaxPoints = snfd_pkg::MaxPoints
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  snfd_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output snfd_pkg::out_word_t  out_data_o
);

  localparam int unsigned CoordBits = snfd_pkg::CoordBits;

  snfd_pkg::dp_cmd_t    cmd;
  logic                 full, one_left, two_left, emit, trunc, busy;
  logic [CoordBits-1:0] key, head, near, far;
  logic                 ovalid_q;
  snfd_pkg::out_word_t  odata_q;

  assign key  = {~in_data_i.coordinate[CoordBits-1], in_data_i.coordinate[CoordBits-2:0]};
  assign busy = ovalid_q && !out_ready_i;

  snfd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .last_i(in_data_i.last_point), .out_busy_i(busy), .full_i(full),
    .one_left_i(one_left), .cmd_o(cmd), .emit_o(emit), .trunc_o(trunc)
  );

  snfd_chain #(.MaxPoints(MaxPoints), .CoordBits(CoordBits)) u_chain (
    .clk_i, .rst_ni, .cmd_i(cmd), .key_i(key), .full_o(full),
    .two_left_o(two_left), .one_left_o(one_left), .head_o(head),
    .near_o(near), .far_o(far)
  );

  // Hold the result word until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      odata_q.point_value       <= {~head[CoordBits-1], head[CoordBits-2:0]};
      odata_q.nearest_distance  <= near;
      odata_q.farthest_distance <= far;
      odata_q.truncated         <= trunc;
      odata_q.last_result       <= !two_left;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // No new input while results are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> !in_ready_o)
    else $error("input ready during emit");
  // An emit never overwrites an untaken word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !emit)
    else $error("output word overwritten");
  // A final result ends the emit phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !two_left) |=> in_ready_o == 1'b0 ##1 in_ready_o)
    else $error("emit phase did not end");

endmodule

[sim/sorted_nearest_farthest_distance_test.sv]
// Testbench for sorted_nearest_farthest_distance: loads point sets, predicts
// the sorted nearest/farthest distances of each set, and checks every result word.
// Depends on snfd_pkg and the block's RTL.
module sorted_nearest_farthest_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordBits = snfd_pkg::CoordBits;
  localparam int unsigned MaxPoints = snfd_pkg::MaxPoints;
  localparam logic [CoordBits-1:0] SignBit = {1'b1, {(CoordBits-1){1'b0}}};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  snfd_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  snfd_pkg::out_word_t out_data_o;

  sorted_nearest_farthest_distance DUT (.*);

  snfd_pkg::in_word_t  point_queue[$];
  snfd_pkg::out_word_t distance_queue[$];
  logic [CoordBits-1:0] held_keys[$];
  logic held_overflow = 1'b0;
  int  error_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_send = 1'b0;
  int  sets_done = 0;

  // Model one accepted point: insert in offset-binary order, emit on last.
  task automatic predict_point(input snfd_pkg::in_word_t w);
    logic [CoordBits-1:0] key, v, lo, hi, dl, dh, a, b;
    snfd_pkg::out_word_t r;
    int pos, n;
    key = w.coordinate ^ SignBit;
    if (held_keys.size() < MaxPoints) begin
      pos = held_keys.size();
      while (pos > 0 && held_keys[pos-1] > key) pos--;
      held_keys.insert(pos, key);
    end else begin
      held_overflow = 1'b1;
    end
    if (!w.last_point) return;
    n = held_keys.size();
    lo = held_keys[0];
    hi = held_keys[n-1];
    for (int i = 0; i < n; i++) begin
      v = held_keys[i];
      r = '0;
      if (n > 1) begin
        dl = v - lo;
        dh = hi - v;
        r.farthest_distance = (dl > dh) ? dl : dh;
        if (i == 0) r.nearest_distance = held_keys[1] - v;
        else if (i == n - 1) r.nearest_distance = v - held_keys[i-1];
        else begin
          a = v - held_keys[i-1];
          b = held_keys[i+1] - v;
          r.nearest_distance = (a < b) ? a : b;
        end
      end
      r.point_value = v ^ SignBit;
      r.truncated = held_overflow;
      r.last_result = (i == n - 1);
      distance_queue.insert(distance_queue.size(), r);
    end
    held_keys.delete();
    held_overflow = 1'b0;
  endtask

  function automatic logic [CoordBits-1:0] rand_coord();
    unique case ($urandom_range(0, 5))
      0: return {1'b1, {(CoordBits-1){1'b0}}};
      1: return {1'b0, {(CoordBits-1){1'b1}}};
      2: return $urandom_range(0, 40) - 20;
      3: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_set(input int n);
    snfd_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.coordinate = rand_coord();
      w.last_point = (i == n - 1);
      point_queue.insert(point_queue.size(), w);
    end
  endtask

  task automatic add_point(input logic [CoordBits-1:0] c, input logic last);
    snfd_pkg::in_word_t w;
    w.coordinate = c;
    w.last_point = last;
    point_queue.insert(point_queue.size(), w);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: hold the word until accepted, idle at random between words.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) predict_point(in_data_i);
        if (point_queue.size() > 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i <= point_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    snfd_pkg::out_word_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (distance_queue.size() == 0) begin
          $error("unexpected word %h", out_data_o);
          error_count++;
        end else begin
          e = distance_queue.pop_front();
          if (out_data_o.point_value !== e.point_value) begin
            $error("point_value exp %h got %h", e.point_value, out_data_o.point_value);
            error_count++;
          end
          if (out_data_o.nearest_distance !== e.nearest_distance) begin
            $error("nearest_distance exp %h got %h", e.nearest_distance,
                   out_data_o.nearest_distance);
            error_count++;
          end
          if (out_data_o.farthest_distance !== e.farthest_distance) begin
            $error("farthest_distance exp %h got %h", e.farthest_distance,
                   out_data_o.farthest_distance);
            error_count++;
          end
          if (out_data_o.truncated !== e.truncated) begin
            $error("truncated exp %b got %b", e.truncated, out_data_o.truncated);
            error_count++;
          end
          if (out_data_o.last_result !== e.last_result) begin
            $error("last_result exp %b got %b", e.last_result, out_data_o.last_result);
            error_count++;
          end
          if (e.last_result) sets_done++;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    while (point_queue.size() > 0 || in_valid_i || distance_queue.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lone point, extremes, duplicates, ties.
    add_point({1'b1, {(CoordBits-1){1'b0}}}, 1'b1);
    add_point({1'b0, {(CoordBits-1){1'b1}}}, 1'b0);
    add_point({1'b1, {(CoordBits-1){1'b0}}}, 1'b1);
    add_point(5, 1'b0);
    add_point(5, 1'b0);
    add_point(-3, 1'b0);
    add_point(13, 1'b1);
    add_point('1, 1'b0);
    add_point(0, 1'b0);
    add_point(1, 1'b1);
    add_point(32'h5555_5555, 1'b0);
    add_point(32'hAAAA_AAAA, 1'b1);
    drain();

    // Queue an overflowing set while the sender is paused, then release it and drain.
    hold_send = 1'b1;
    add_set(MaxPoints + 3);
    repeat (20) @(posedge clk_i);
    hold_send = 1'b0;
    drain();

    // Random sets across idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int s = 0; s < 3; s++) add_set($urandom_range(1, 8));
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (error_count == 0 && distance_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

[sorted_nearest_farthest_distance.f]
rtl/snfd_pkg.sv
rtl/snfd_chain.sv
rtl/snfd_ctrl.sv
rtl/sorted_nearest_farthest_distance.sv
sim/sorted_nearest_farthest_distance_test.sv
